@@ hdl/nci_pkg.sv @@
// Shared types, constants and weight tables for the Newton-Cotes integrator.
package nci_pkg;

  localparam int MAX_INTERVALS = 4096;
  localparam int CNT_W         = 13;
  localparam int STEP_W        = 32;
  localparam int SAMPLE_W      = 32;
  localparam int RES_W         = 64;
  localparam int SUM_W         = 64;
  localparam int WGT_W         = 7;
  localparam int DEN_W         = 6;
  localparam int PROD_W        = 96;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = 2;
  localparam int FIFO_CW       = 3;

  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_INTERVALS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 2'd1;

  // Saturation bounds of the Q32.32 result
  localparam logic [RES_W-1:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [RES_W-1:0] SAT_NEG = 64'h8000_0000_0000_0000;

  // One classified sample in flight from front to back
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [WGT_W-1:0]    weight;
    logic                last;
  } nci_item_t;

  // Live configuration seen by the back end
  typedef struct packed {
    logic [CNT_W-1:0]  n_eff;
    logic [STEP_W-1:0] step;
    logic              restart;
  } nci_cfg_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } nci_fifo_st_t;

  // Weight numerator for position p of an n-interval rule
  function automatic logic [WGT_W-1:0] nci_weight(input logic [CNT_W-1:0] n,
                                                  input logic [CNT_W-1:0] p);
    logic [CNT_W-1:0] rem_p;
    logic [CNT_W-1:0] d;
    logic [WGT_W-1:0] w;
    rem_p = n - p;
    d     = (p <= rem_p) ? p : rem_p;
    priority if (n == 13'd0) begin
      w = 7'd0;
    end else if (n == 13'd1) begin
      w = 7'd1;
    end else if (n == 13'd2) begin
      w = (d == 13'd0) ? 7'd1 : 7'd4;
    end else if (n == 13'd3) begin
      w = (d == 13'd0) ? 7'd3 : 7'd9;
    end else if (n == 13'd4) begin
      w = (d == 13'd0) ? 7'd14 : ((d == 13'd1) ? 7'd64 : 7'd24);
    end else begin
      priority if (d == 13'd0) w = 7'd9;
      else if (d == 13'd1) w = 7'd28;
      else if (d == 13'd2) w = 7'd23;
      else w = 7'd24;
    end
    return w;
  endfunction

  // Common denominator of the n-interval rule
  function automatic logic [DEN_W-1:0] nci_den(input logic [CNT_W-1:0] n);
    logic [DEN_W-1:0] den;
    priority if (n == 13'd0) den = 6'd1;
    else if (n == 13'd1) den = 6'd2;
    else if (n == 13'd2) den = 6'd3;
    else if (n == 13'd3) den = 6'd8;
    else if (n == 13'd4) den = 6'd45;
    else den = 6'd24;
    return den;
  endfunction

endpackage

@@ hdl/nci_front.sv @@
// Front end: configuration registers, sample position tracking and weight lookup.
module nci_front import nci_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  input  logic [SAMPLE_W-1:0]  in_sample,
  input  nci_fifo_st_t         fifo_st,
  output logic                 push,
  output nci_item_t            item,
  output nci_cfg_t             cfg
);

  logic [CNT_W-1:0]  count_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  p_eff;
  logic              restart;
  logic              last;

  assign restart = cfg_we && ((cfg_index == REG_INTERVAL_COUNT) ||
                              (cfg_index == REG_STEP_SIZE));
  assign n_eff   = (count_r > MAX_N) ? MAX_N : count_r;
  assign p_eff   = (pos_r > n_eff) ? n_eff : pos_r;
  assign last    = (p_eff == n_eff);
  assign push    = in_valid && !fifo_st.full;

  assign item.sample = in_sample;
  assign item.weight = nci_weight(n_eff, p_eff);
  assign item.last   = last;

  assign cfg.n_eff   = n_eff;
  assign cfg.step    = step_r;
  assign cfg.restart = restart;

  // Advance the position, wrap at the block end, drop to zero on restart
  always_comb begin
    pos_nxt = pos_r;
    if (restart) begin
      pos_nxt = '0;
    end else if (push) begin
      pos_nxt = last ? '0 : p_eff + 13'd1;
    end
  end

  // Hold configuration and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      step_r  <= 32'd65536;
      pos_r   <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (cfg_we && (cfg_index == REG_INTERVAL_COUNT)) begin
        count_r <= cfg_wdata[CNT_W-1:0];
      end
      if (cfg_we && (cfg_index == REG_STEP_SIZE)) begin
        step_r <= cfg_wdata[STEP_W-1:0];
      end
    end
  end

endmodule

@@ hdl/nci_fifo.sv @@
// Short queue of classified samples between front and back ends.
module nci_fifo import nci_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  nci_item_t    push_item,
  input  logic         pop,
  output nci_item_t    pop_item,
  output nci_fifo_st_t st
);

  nci_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign st.full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign st.empty = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  // Track occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 3'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 3'd1;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 2'd1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hdl/nci_back.sv @@
// Back end: multiply-accumulate, scale by h, divide by the rule denominator, saturate.
module nci_back import nci_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  nci_cfg_t          cfg,
  input  nci_fifo_st_t      fifo_st,
  input  nci_item_t         item,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [RES_W-1:0]  out_integral,
  output logic              out_saturated
);

  localparam logic [2:0] S_ACC  = 3'd0;
  localparam logic [2:0] S_ABS  = 3'd1;
  localparam logic [2:0] S_MUL0 = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_RND  = 3'd6;
  localparam logic [2:0] S_SAT  = 3'd7;

  localparam logic [6:0] DIV_LAST = 7'(PROD_W - 1);

  logic [2:0]        state_r, state_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [SUM_W-1:0]  plo_r, plo_nxt;
  logic [SUM_W-1:0]  phi_r, phi_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [6:0]        bit_r, bit_nxt;
  logic              ov_r, ov_nxt;
  logic [RES_W-1:0]  res_r, res_nxt;
  logic              sat_r, sat_nxt;

  logic [SUM_W-1:0]  mac_prod;
  logic [SUM_W-1:0]  mac_sum;
  logic [DEN_W:0]    trial;
  logic              qbit;
  logic              round_up;
  logic              out_free;
  logic [RES_W-1:0]  lim;
  logic              clip;
  logic [RES_W-1:0]  mag_res;

  assign pop      = (state_r == S_ACC) && !fifo_st.empty;
  assign mac_prod = {{(SUM_W-SAMPLE_W){item.sample[SAMPLE_W-1]}}, item.sample} *
                    {{(SUM_W-WGT_W){1'b0}}, item.weight};
  assign mac_sum  = sum_r + mac_prod;
  assign trial    = {rem_r, quo_r[PROD_W-1]};
  assign qbit     = (trial >= {1'b0, den_r});
  assign round_up = ({rem_r, 1'b0} >= {1'b0, den_r});
  assign out_free = !ov_r || !out_stall;
  assign lim      = neg_r ? SAT_NEG : SAT_POS;
  assign clip     = (quo_r[PROD_W-1:RES_W] != '0) || (quo_r[RES_W-1:0] > lim);
  assign mag_res  = clip ? lim : quo_r[RES_W-1:0];

  assign out_valid     = ov_r;
  assign out_integral  = res_r;
  assign out_saturated = sat_r;

  // Accumulate samples, then sequence each block end through scale, divide, round and saturate
  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    den_nxt   = den_r;
    plo_nxt   = plo_r;
    phi_nxt   = phi_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    ov_nxt    = ov_r && out_stall;
    res_nxt   = res_r;
    sat_nxt   = sat_r;
    unique case (state_r)
      S_ACC: begin
        if (pop) begin
          if (item.last) begin
            sum_nxt   = '0;
            mag_nxt   = mac_sum;
            neg_nxt   = mac_sum[SUM_W-1];
            den_nxt   = nci_den(cfg.n_eff);
            state_nxt = S_ABS;
          end else begin
            sum_nxt = mac_sum;
          end
        end
      end
      S_ABS: begin
        mag_nxt   = neg_r ? '0 - mag_r : mag_r;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        plo_nxt   = {32'd0, mag_r[31:0]} * {32'd0, cfg.step};
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        phi_nxt   = {32'd0, mag_r[63:32]} * {32'd0, cfg.step};
        state_nxt = S_SUM;
      end
      S_SUM: begin
        quo_nxt   = {phi_r, 32'd0} + {32'd0, plo_r};
        rem_nxt   = '0;
        bit_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quo_nxt = {quo_r[PROD_W-2:0], qbit};
        rem_nxt = qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        bit_nxt = bit_r + 7'd1;
        if (bit_r == DIV_LAST) state_nxt = S_RND;
      end
      S_RND: begin
        quo_nxt   = quo_r + PROD_W'(round_up);
        state_nxt = S_SAT;
      end
      S_SAT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          res_nxt   = neg_r ? '0 - mag_res : mag_res;
          sat_nxt   = clip;
          state_nxt = S_ACC;
        end
      end
      default: state_nxt = S_ACC;
    endcase
    if (cfg.restart) sum_nxt = '0;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      sum_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    bit_r <= bit_nxt;
    res_r <= res_nxt;
    sat_r <= sat_nxt;
  end

endmodule

@@ hdl/newton_cotes_integrator_core.sv @@
// Newton-Cotes quadrature core: samples in, one Q32.32 integral per block out.
// Throughput: one sample per cycle while the queue has room; at a block end the back
//   end takes no samples while it runs abs, two 32x32 products, a 96-step divider,
//   rounding and saturation, and samples wait in the queue meanwhile.
// Reset: synchronous active-low; clears position, running sum, queue and output
//   valid; interval_count returns to 0 and step_size to 1.0.
module newton_cotes_integrator_core import nci_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] out_integral,
  output logic                    out_saturated
);

  nci_item_t    push_item;
  nci_item_t    pop_item;
  nci_cfg_t     cfg;
  nci_fifo_st_t fifo_st;
  logic         push;
  logic         pop;
  logic [RES_W-1:0] integral;

  assign in_stall     = fifo_st.full;
  assign out_integral = $signed(integral);

  nci_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_sample (in_sample),
    .fifo_st   (fifo_st),
    .push      (push),
    .item      (push_item),
    .cfg       (cfg)
  );

  nci_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .st        (fifo_st)
  );

  nci_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .fifo_st       (fifo_st),
    .item          (pop_item),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_integral  (integral),
    .out_saturated (out_saturated)
  );

  // No result is presented right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // A clipped result sits on one of the two bounds
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      ((integral == SAT_POS) || (integral == SAT_NEG)))
    else $error("saturated result off the bounds");

  // Queue is never both full and empty
  a_fifo_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(fifo_st.full && fifo_st.empty))
    else $error("queue flags inconsistent");

endmodule
